### rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and defaults for the bitonic sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int DEF_BLOCK_SIZE     = 16;
    localparam int DEF_LOG_BLOCK_SIZE = 4;
    localparam int DATA_W             = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_WRHI,
        ST_UNLOAD
    } t_state;

    // sequencer -> pair generator
    typedef struct packed {
        logic init;
        logic step;
    } t_pgen_ctl;

endpackage

### rtl/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/bse_pair_gen.sv
// ----------------------------------------------------------------------------
// bse_pair_gen
// Walks the bitonic network: stage, pass and pair counters, and the
// lower/upper index of the current compare-exchange.
// ----------------------------------------------------------------------------
module bse_pair_gen #(
    parameter int BLOCK_SIZE     = bse_pkg::DEF_BLOCK_SIZE,
    parameter int LOG_BLOCK_SIZE = bse_pkg::DEF_LOG_BLOCK_SIZE,
    localparam int AW            = $clog2(BLOCK_SIZE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bse_pkg::t_pgen_ctl i_ctl,
    output logic [AW-1:0]      o_lo,
    output logic [AW-1:0]      o_hi,
    output logic               o_in_range,
    output logic               o_last
);

    import bse_pkg::*;

    localparam int SW = $clog2(LOG_BLOCK_SIZE + 1);
    localparam int KW = LOG_BLOCK_SIZE;
    localparam int IW = ((LOG_BLOCK_SIZE > AW) ? LOG_BLOCK_SIZE : AW) + 1;
    localparam logic [KW-1:0] KLAST = KW'((1 << (LOG_BLOCK_SIZE - 1)) - 1);
    localparam logic [SW-1:0] SLAST = SW'(LOG_BLOCK_SIZE - 1);
    localparam logic [IW-1:0] NSIZE = IW'(BLOCK_SIZE);

    logic [SW-1:0] r_stage, n_stage;
    logic [SW-1:0] r_dlog,  n_dlog;
    logic          r_mirror, n_mirror;
    logic [KW-1:0] r_k,     n_k;

    logic [IW-1:0] kx, mask, lo, hi;

    // lo inserts a zero bit at position dlog of the pair index
    always_comb begin
        kx   = IW'(r_k);
        mask = (IW'(1) << r_dlog) - IW'(1);
        lo   = ((kx & ~mask) << 1) | (kx & mask);
        if (r_mirror) begin
            hi = lo ^ ((mask << 1) | IW'(1));
        end else begin
            hi = lo | (mask + IW'(1));
        end
    end

    assign o_lo       = lo[AW-1:0];
    assign o_hi       = hi[AW-1:0];
    assign o_in_range = (hi < NSIZE);
    assign o_last     = (r_k == KLAST) && (r_dlog == '0) && (r_stage == SLAST);

    always_comb begin
        n_stage  = r_stage;
        n_dlog   = r_dlog;
        n_mirror = r_mirror;
        n_k      = r_k;
        if (i_ctl.init) begin
            n_stage  = '0;
            n_dlog   = '0;
            n_mirror = 1'b1;
            n_k      = '0;
        end else if (i_ctl.step) begin
            if (r_k != KLAST) begin
                n_k = r_k + KW'(1);
            end else begin
                n_k = '0;
                if (r_dlog == '0) begin
                    n_stage  = r_stage + SW'(1);
                    n_dlog   = r_stage + SW'(1);
                    n_mirror = 1'b1;
                end else begin
                    n_dlog   = r_dlog - SW'(1);
                    n_mirror = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= '0;
            r_dlog   <= '0;
            r_mirror <= 1'b1;
            r_k      <= '0;
        end else begin
            r_stage  <= n_stage;
            r_dlog   <= n_dlog;
            r_mirror <= n_mirror;
            r_k      <= n_k;
        end
    end

endmodule

### rtl/bitonic_sort_engine_top.sv
// ----------------------------------------------------------------------------
// bitonic_sort_engine_top
// Collects a block of unsigned 32-bit values, sorts it in place with a
// bitonic network on one shared comparator, then streams it out ascending.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------
//  input     | in        | start & !busy           | i_sample_value
//  result    | out       | o_result_valid (strobe) | o_sorted_value, o_last_flag
//
//  Load takes one cycle per value; busy stays low until the block's last value.
//  Sorting: C = (2^LOG/2)*LOG*(LOG+1)/2 compare-exchanges on one comparator
//  through the buffer RAM, each in ST_READ then ST_CMP (plus ST_WRHI when the
//  pair swaps, ST_READ alone beyond the block); 80 for a block of 16.
//  Unload: one result per cycle; busy drops as the last result is shown.
//  Synchronous active-low reset clears the fill count and sequencer; results
//  cannot be stalled.
// ----------------------------------------------------------------------------
module bitonic_sort_engine_top #(
    parameter int BLOCK_SIZE     = bse_pkg::DEF_BLOCK_SIZE,
    parameter int LOG_BLOCK_SIZE = bse_pkg::DEF_LOG_BLOCK_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bse_pkg::DATA_W-1:0]  i_sample_value,
    output logic                        o_result_valid,
    output logic [bse_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                        o_last_flag
);

    import bse_pkg::*;

    localparam int AW = $clog2(BLOCK_SIZE);
    localparam int FW = $clog2(BLOCK_SIZE + 1);
    localparam logic [FW-1:0] FLAST = FW'(BLOCK_SIZE - 1);
    localparam logic [AW-1:0] ILAST = AW'(BLOCK_SIZE - 1);

    t_state r_state, n_state;

    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_idx,  n_idx;
    logic [DATA_W-1:0] r_hold;
    logic              r_rd_pend, r_rd_last;

    logic              accept;
    logic              swap;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr_a, ram_raddr_b;
    logic [DATA_W-1:0] ram_rdata_a, ram_rdata_b;

    t_pgen_ctl         pg_ctl;
    logic [AW-1:0]     pg_lo, pg_hi;
    logic              pg_in_range, pg_last;

    bse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BLOCK_SIZE)
    ) u_buf (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    bse_pair_gen #(
        .BLOCK_SIZE     (BLOCK_SIZE),
        .LOG_BLOCK_SIZE (LOG_BLOCK_SIZE)
    ) u_pgen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pg_ctl),
        .o_lo       (pg_lo),
        .o_hi       (pg_hi),
        .o_in_range (pg_in_range),
        .o_last     (pg_last)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign swap   = (ram_rdata_a > ram_rdata_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (r_fill == FLAST)) n_state = ST_READ;
            end
            ST_READ: begin
                if (pg_in_range)  n_state = ST_CMP;
                else if (pg_last) n_state = ST_UNLOAD;
            end
            ST_CMP: begin
                if (swap)         n_state = ST_WRHI;
                else if (pg_last) n_state = ST_UNLOAD;
                else              n_state = ST_READ;
            end
            ST_WRHI: begin
                n_state = pg_last ? ST_UNLOAD : ST_READ;
            end
            ST_UNLOAD: begin
                if (r_idx == ILAST) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = pg_lo;
        ram_wdata   = ram_rdata_b;
        ram_raddr_a = pg_lo;
        ram_raddr_b = pg_hi;
        pg_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                ram_we      = accept;
                ram_waddr   = r_fill[AW-1:0];
                ram_wdata   = i_sample_value;
                pg_ctl.init = 1'b1;
            end
            ST_READ: begin
                pg_ctl.step = !pg_in_range;
            end
            ST_CMP: begin
                // smaller value goes to the lower index
                ram_we      = swap;
                pg_ctl.step = !swap;
            end
            ST_WRHI: begin
                ram_we      = 1'b1;
                ram_waddr   = pg_hi;
                ram_wdata   = r_hold;
                pg_ctl.step = 1'b1;
            end
            ST_UNLOAD: begin
                ram_raddr_a = r_idx;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = (r_fill == FLAST) ? '0 : r_fill + FW'(1);
        end
        n_idx = r_idx;
        if (r_state == ST_UNLOAD) begin
            n_idx = (r_idx == ILAST) ? '0 : r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_rd_pend <= (r_state == ST_UNLOAD);
            r_rd_last <= (r_state == ST_UNLOAD) && (r_idx == ILAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CMP) begin
            r_hold <= ram_rdata_a;
        end
    end

    assign o_result_valid = r_rd_pend;
    assign o_sorted_value = ram_rdata_a;
    assign o_last_flag    = r_rd_last;

endmodule

### sim/bitonic_sort_engine_top_tb.sv
// ----------------------------------------------------------------------------
// bitonic_sort_engine_top_tb
// Loads blocks of 32-bit values through the start/busy handshake and checks
// every streamed result against a local bitonic-network predictor. Covers an
// extreme-value block, ordered and constant blocks, duplicate-heavy blocks
// and random blocks, with random input gaps and one long gap-free stretch.
// ----------------------------------------------------------------------------
module bitonic_sort_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK       = bse_pkg::DEF_BLOCK_SIZE;
    localparam int LOG_BLK   = bse_pkg::DEF_LOG_BLOCK_SIZE;
    localparam int CYCLE_MAX = 200000;
    localparam int PRINT_MAX = 20;

    typedef enum int {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_ASCEND,
        PAT_DESCEND,
        PAT_CONST,
        PAT_EXTREME
    } t_pattern;

    typedef struct {
        logic [bse_pkg::DATA_W-1:0] value;
        logic                       last;
    } t_sorted_entry;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        start          = 1'b0;
    logic                        busy;
    logic [bse_pkg::DATA_W-1:0]  i_sample_value = '0;
    logic                        o_result_valid;
    logic [bse_pkg::DATA_W-1:0]  o_sorted_value;
    logic                        o_last_flag;

    // predictor state
    logic [bse_pkg::DATA_W-1:0]  pending_block [BLK];
    int                          pending_count = 0;
    t_sorted_entry               expected_sorted [$];

    logic [bse_pkg::DATA_W-1:0]  staging_block [BLK];
    bit                          gaps_enabled = 1'b1;
    int                          error_count = 0;
    int                          results_checked = 0;
    int                          blocks_sent = 0;
    int                          samples_sent = 0;
    int                          cycle_count = 0;

    bitonic_sort_engine_top #(
        .BLOCK_SIZE     (BLK),
        .LOG_BLOCK_SIZE (LOG_BLK)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_value (i_sample_value),
        .o_result_valid (o_result_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_flag    (o_last_flag)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= PRINT_MAX)
            $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // smaller value to the lower index; pairs past the block are skipped
    function automatic void order_pair(int lo, int hi);
        logic [bse_pkg::DATA_W-1:0] t;
        if (lo >= BLK || hi >= BLK)
            return;
        if (pending_block[lo] > pending_block[hi]) begin
            t                 = pending_block[lo];
            pending_block[lo] = pending_block[hi];
            pending_block[hi] = t;
        end
    endfunction

    function automatic void bitonic_network();
        int span;
        int half;
        int grp;
        span = 1 << LOG_BLK;
        for (int stage = 0; stage < LOG_BLK; stage++) begin
            half = 1 << stage;
            grp  = half << 1;
            // mirrored pairs
            for (int base = 0; base < span; base += grp)
                for (int off = 0; off < half; off++)
                    order_pair(base + off, base + grp - 1 - off);
            // half-cleaners
            for (int pass = 1; pass <= stage; pass++) begin
                grp  = grp >> 1;
                half = half >> 1;
                for (int base = 0; base < span; base += grp)
                    for (int off = 0; off < half; off++)
                        order_pair(base + off, base + off + half);
            end
        end
    endfunction

    function automatic void predict_sample(logic [bse_pkg::DATA_W-1:0] value);
        t_sorted_entry e;
        if (pending_count >= BLK)
            pending_count = 0;
        pending_block[pending_count] = value;
        pending_count++;
        if (pending_count == BLK) begin
            bitonic_network();
            for (int i = 0; i < BLK; i++) begin
                e.value = pending_block[i];
                e.last  = (i == BLK - 1);
                expected_sorted.push_back(e);
            end
            pending_count = 0;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_sorted_entry want;
        if (i_rst_n && o_result_valid) begin
            if (expected_sorted.size() == 0) begin
                report_mismatch("result with nothing pending", '0, o_sorted_value);
            end else begin
                want = expected_sorted.pop_front();
                results_checked++;
                if (o_sorted_value !== want.value)
                    report_mismatch("sorted_value", want.value, o_sorted_value);
                if (o_last_flag !== want.last)
                    report_mismatch("last_flag", 32'(want.last), 32'(o_last_flag));
            end
        end
    end

    // one transaction: hold start until the engine takes it
    task automatic send_sample(input logic [bse_pkg::DATA_W-1:0] value);
        start          <= 1'b1;
        i_sample_value <= value;
        do @(posedge i_clk); while (busy);
        predict_sample(value);
        samples_sent++;
        if (gaps_enabled && $urandom_range(0, 99) < 10) begin
            start          <= 1'b0;
            i_sample_value <= $urandom;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_staged_block();
        for (int i = 0; i < BLK; i++)
            send_sample(staging_block[i]);
        blocks_sent++;
    endtask

    task automatic send_pattern_block(input t_pattern pat);
        logic [bse_pkg::DATA_W-1:0] base;
        logic [bse_pkg::DATA_W-1:0] step;
        logic [bse_pkg::DATA_W-1:0] picks [5];
        base  = $urandom;
        step  = $urandom_range(0, 1000);
        picks = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
        for (int i = 0; i < BLK; i++) begin
            case (pat)
                PAT_NARROW:  staging_block[i] = {base[31:2], 2'($urandom)};
                PAT_ASCEND:  staging_block[i] = base[31:1] + i * step;
                PAT_DESCEND: staging_block[i] = base[31:1] + (BLK - 1 - i) * step;
                PAT_CONST:   staging_block[i] = base;
                PAT_EXTREME: staging_block[i] = picks[$urandom_range(0, 4)];
                default:     staging_block[i] = $urandom;
            endcase
        end
        send_staged_block();
    endtask

    task automatic run_reset();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // extremes and duplicates in one block
    task automatic test_extreme_block();
        staging_block = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h1, 32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h2, 32'h0001_0000,
                          32'hFFFF_0000, 32'h0000_FFFF, 32'h1, 32'h8000_0001};
        send_staged_block();
    endtask

    task automatic test_ordered_blocks();
        send_pattern_block(PAT_ASCEND);
        send_pattern_block(PAT_DESCEND);
        send_pattern_block(PAT_CONST);
        send_pattern_block(PAT_EXTREME);
    endtask

    task automatic test_duplicate_blocks();
        repeat (4) send_pattern_block(PAT_NARROW);
    endtask

    task automatic test_random_blocks();
        t_pattern pat;
        for (int b = 0; b < 24; b++) begin
            // gap-free stretch in the middle
            gaps_enabled = !(b >= 8 && b < 16);
            if ($urandom_range(0, 99) < 60)
                pat = PAT_RANDOM;
            else
                pat = t_pattern'($urandom_range(PAT_NARROW, PAT_EXTREME));
            send_pattern_block(pat);
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        run_reset();
        test_extreme_block();
        test_ordered_blocks();
        test_duplicate_blocks();
        test_random_blocks();
        start <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_count != 0 || expected_sorted.size() != 0)
            report_mismatch("values left pending", 32'h0, 32'(expected_sorted.size()));
        $display("sent %0d blocks (%0d values), checked %0d sorted results, %0d errors",
                 blocks_sent, samples_sent, results_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
